[src/gb3_pkg.sv]
// Package for the 3x3 binomial RGBA blur: shared constants, codes and types.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package gb3_pkg;

    localparam int MAX_WIDTH_DEF     = 1024;
    localparam int WIDTH_RESET       = 1024;
    localparam int HEIGHT_RESET      = 1024;
    localparam int HEIGHT_LIMIT      = 4096;

    localparam int CH_W              = 8;
    localparam int CHANNELS          = 4;
    localparam int PIX_W             = CH_W * CHANNELS;
    localparam int BLUR_SUM_W        = CH_W + 4;
    localparam int WIN_SIZE          = 9;

    localparam int CFG_DATA_W        = 13;
    localparam int CFG_IDX_W         = 1;
    localparam int CFG_WIDTH_FIELD_W = 11;
    localparam int ROW_W             = 13;
    localparam int OUT_Y_W           = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    localparam int OUT_DEPTH = 3;
    localparam int OUT_PTR_W = 2;
    localparam int OUT_CNT_W = 2;

    typedef logic [PIX_W-1:0] pix_t;

    typedef struct packed {
        logic valid;
        logic pixel;
        logic emit;
        logic interior;
        logic sel_mid;
        logic last;
    } s1_ctrl_t;

    typedef struct packed {
        pix_t pix;
        logic frame_end;
    } out_item_t;

endpackage

`default_nettype wire

[src/gb3_ctrl.sv]
// Position counters, size registers and first pipeline stage of the blur.
// Uses gb3_pkg; drives the line store read port and the stage-one control.
`default_nettype none

module gb3_ctrl #(
    parameter int MAX_WIDTH = gb3_pkg::MAX_WIDTH_DEF,
    localparam int COL_W = $clog2(MAX_WIDTH)
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             accept,
    input  wire logic                             func,
    input  wire gb3_pkg::pix_t                    in_px,
    input  wire logic                             cfg_wr_en,
    input  wire logic [gb3_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [gb3_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                                  rd_en,
    output logic [COL_W-1:0]                      rd_addr,
    output gb3_pkg::s1_ctrl_t                     s1_ctrl,
    output logic [COL_W-1:0]                      s1_addr,
    output gb3_pkg::pix_t                         s1_px
);

    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W = (WID_W > gb3_pkg::CFG_WIDTH_FIELD_W) ?
                           WID_W : gb3_pkg::CFG_WIDTH_FIELD_W;
    localparam int RESET_W = (MAX_WIDTH < gb3_pkg::WIDTH_RESET) ?
                             MAX_WIDTH : gb3_pkg::WIDTH_RESET;
    localparam int ROW_W = gb3_pkg::ROW_W;
    localparam int Y_W   = gb3_pkg::OUT_Y_W;

    logic [WID_W-1:0]  w_reg, w_next;
    logic [ROW_W-1:0]  h_reg, h_next;
    logic [COL_W-1:0]  in_col_reg, in_col_next;
    logic [ROW_W-1:0]  in_row_reg, in_row_next;
    logic [COL_W-1:0]  out_x_reg, out_x_next;
    logic [Y_W-1:0]    out_y_reg, out_y_next;
    gb3_pkg::s1_ctrl_t s1_ctrl_reg, s1_ctrl_next;
    logic [COL_W-1:0]  s1_addr_reg, s1_addr_next;
    gb3_pkg::pix_t     s1_px_reg, s1_px_next;

    logic [CMP_W-1:0]  w_raw;
    logic [WID_W-1:0]  w_clamp;
    logic [ROW_W-1:0]  h_clamp;
    logic              complete;
    logic              is_pixel;
    logic              emit_px;
    logic              col_last;
    logic              x_last;
    logic              y_last;
    logic              interior;

    always_comb
    begin
        w_raw = CMP_W'(cfg_data[gb3_pkg::CFG_WIDTH_FIELD_W-1:0]);
        if (w_raw == '0)
        begin
            w_clamp = WID_W'(1);
        end
        else if (w_raw > CMP_W'(MAX_WIDTH))
        begin
            w_clamp = WID_W'(MAX_WIDTH);
        end
        else
        begin
            w_clamp = WID_W'(w_raw);
        end

        if (cfg_data == '0)
        begin
            h_clamp = ROW_W'(1);
        end
        else if (cfg_data > ROW_W'(gb3_pkg::HEIGHT_LIMIT))
        begin
            h_clamp = ROW_W'(gb3_pkg::HEIGHT_LIMIT);
        end
        else
        begin
            h_clamp = cfg_data;
        end
    end

    assign complete = (in_row_reg >= h_reg);
    assign is_pixel = (func == gb3_pkg::FUNC_PIXEL) && !complete;
    assign emit_px  = (in_row_reg >= ROW_W'(2)) ||
                      ((in_row_reg == ROW_W'(1)) && (in_col_reg != '0));
    assign col_last = ((WID_W'(in_col_reg) + WID_W'(1)) == w_reg);
    assign x_last   = ((WID_W'(out_x_reg) + WID_W'(1)) == w_reg);
    assign y_last   = ((ROW_W'(out_y_reg) + ROW_W'(1)) >= h_reg);
    assign interior = (out_x_reg != '0) && ((WID_W'(out_x_reg) + WID_W'(1)) < w_reg) &&
                      (out_y_reg != '0) && !y_last;

    always_comb
    begin
        w_next       = w_reg;
        h_next       = h_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_x_next   = out_x_reg;
        out_y_next   = out_y_reg;
        s1_ctrl_next = '0;
        s1_addr_next = s1_addr_reg;
        s1_px_next   = s1_px_reg;
        rd_en        = 1'b0;
        rd_addr      = in_col_reg;

        if (cfg_wr_en)
        begin
            case (cfg_index)
                gb3_pkg::CFG_IMAGE_WIDTH:  w_next = w_clamp;
                gb3_pkg::CFG_IMAGE_HEIGHT: h_next = h_clamp;
                default:                   w_next = w_reg;
            endcase
            in_col_next = '0;
            in_row_next = '0;
            out_x_next  = '0;
            out_y_next  = '0;
        end
        else if (accept && is_pixel)
        begin
            rd_en                 = 1'b1;
            rd_addr               = in_col_reg;
            s1_ctrl_next.valid    = 1'b1;
            s1_ctrl_next.pixel    = 1'b1;
            s1_ctrl_next.emit     = emit_px;
            s1_ctrl_next.interior = interior;
            s1_addr_next          = in_col_reg;
            s1_px_next            = in_px;
            if (col_last)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + ROW_W'(1);
            end
            else
            begin
                in_col_next = in_col_reg + COL_W'(1);
            end
            if (emit_px)
            begin
                if (x_last)
                begin
                    out_x_next = '0;
                    out_y_next = out_y_reg + Y_W'(1);
                end
                else
                begin
                    out_x_next = out_x_reg + COL_W'(1);
                end
            end
        end
        else if (accept && complete)
        begin
            rd_en                = 1'b1;
            rd_addr              = out_x_reg;
            s1_ctrl_next.valid   = 1'b1;
            s1_ctrl_next.emit    = 1'b1;
            s1_ctrl_next.sel_mid = y_last;
            s1_ctrl_next.last    = x_last && y_last;
            s1_addr_next         = out_x_reg;
            if (x_last && y_last)
            begin
                in_col_next = '0;
                in_row_next = '0;
                out_x_next  = '0;
                out_y_next  = '0;
            end
            else if (x_last)
            begin
                out_x_next = '0;
                out_y_next = out_y_reg + Y_W'(1);
            end
            else
            begin
                out_x_next = out_x_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg       <= WID_W'(RESET_W);
            h_reg       <= ROW_W'(gb3_pkg::HEIGHT_RESET);
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_x_reg   <= '0;
            out_y_reg   <= '0;
            s1_ctrl_reg <= '0;
        end
        else
        begin
            w_reg       <= w_next;
            h_reg       <= h_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_x_reg   <= out_x_next;
            out_y_reg   <= out_y_next;
            s1_ctrl_reg <= s1_ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_addr_reg <= s1_addr_next;
        s1_px_reg   <= s1_px_next;
    end

    assign s1_ctrl = s1_ctrl_reg;
    assign s1_addr = s1_addr_reg;
    assign s1_px   = s1_px_reg;

    // The input column always stays inside the current row.
    assert property (@(posedge clk) disable iff (!rst_n)
        (WID_W'(in_col_reg) < w_reg))
        else $error("input column outside the row");

    // The output row never passes the frame height.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ROW_W'(out_y_reg) < h_reg))
        else $error("output row outside the frame");

    // The last drain transaction returns every position to the frame start.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !cfg_wr_en && complete && !is_pixel && x_last && y_last) |=>
        (in_col_reg == '0 && in_row_reg == '0 && out_x_reg == '0 && out_y_reg == '0))
        else $error("positions not cleared at frame end");

endmodule

`default_nettype wire

[src/gb3_line_store.sv]
// Upper and middle line memories with registered reads, write-to-read forwarding
// and the clearing pass after reset. Uses gb3_pkg.
`default_nettype none

module gb3_line_store #(
    parameter int MAX_WIDTH = gb3_pkg::MAX_WIDTH_DEF,
    localparam int COL_W = $clog2(MAX_WIDTH)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rd_en,
    input  wire logic [COL_W-1:0]  rd_addr,
    input  wire logic              wr_en,
    input  wire logic [COL_W-1:0]  wr_addr,
    input  wire gb3_pkg::pix_t     wr_px,
    output gb3_pkg::pix_t          up_rd,
    output gb3_pkg::pix_t          mid_rd,
    output logic                   clr_busy
);

    gb3_pkg::pix_t    upper_mem  [MAX_WIDTH];
    gb3_pkg::pix_t    middle_mem [MAX_WIDTH];

    gb3_pkg::pix_t    upper_q_reg;
    gb3_pkg::pix_t    middle_q_reg;
    gb3_pkg::pix_t    byp_up_reg;
    gb3_pkg::pix_t    byp_mid_reg;
    logic             byp_hit_reg, byp_hit_next;
    logic             clr_active_reg, clr_active_next;
    logic [COL_W-1:0] clr_addr_reg, clr_addr_next;

    logic             mem_we;
    logic [COL_W-1:0] mem_wa;
    gb3_pkg::pix_t    mem_up_d;
    gb3_pkg::pix_t    mem_mid_d;

    assign up_rd  = byp_hit_reg ? byp_up_reg  : upper_q_reg;
    assign mid_rd = byp_hit_reg ? byp_mid_reg : middle_q_reg;

    always_comb
    begin
        mem_we    = clr_active_reg || wr_en;
        mem_wa    = clr_active_reg ? clr_addr_reg : wr_addr;
        mem_up_d  = clr_active_reg ? '0 : mid_rd;
        mem_mid_d = clr_active_reg ? '0 : wr_px;

        byp_hit_next    = rd_en && mem_we && (mem_wa == rd_addr);
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg)
        begin
            if (clr_addr_reg == COL_W'(MAX_WIDTH - 1))
            begin
                clr_active_next = 1'b0;
            end
            else
            begin
                clr_addr_next = clr_addr_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            upper_mem[mem_wa]  <= mem_up_d;
            middle_mem[mem_wa] <= mem_mid_d;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            upper_q_reg  <= upper_mem[rd_addr];
            middle_q_reg <= middle_mem[rd_addr];
        end
        byp_up_reg  <= mem_up_d;
        byp_mid_reg <= mem_mid_d;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_hit_reg    <= 1'b0;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else
        begin
            byp_hit_reg    <= byp_hit_next;
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
        end
    end

    assign clr_busy = clr_active_reg;

    // No read may be issued while the memories are still being cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> !clr_active_reg)
        else $error("line store read during clearing pass");

endmodule

`default_nettype wire

[src/gb3_window.sv]
// 3x3 window registers, binomial blur and result selection for stage one.
// Uses gb3_pkg; fed by gb3_ctrl and gb3_line_store.
`default_nettype none

module gb3_window (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire gb3_pkg::s1_ctrl_t  s1_ctrl,
    input  wire gb3_pkg::pix_t      s1_px,
    input  wire gb3_pkg::pix_t      up_rd,
    input  wire gb3_pkg::pix_t      mid_rd,
    output logic                    push,
    output gb3_pkg::out_item_t      push_item
);

    localparam int CH_W  = gb3_pkg::CH_W;
    localparam int SUM_W = gb3_pkg::BLUR_SUM_W;

    gb3_pkg::pix_t win_reg  [gb3_pkg::WIN_SIZE];
    gb3_pkg::pix_t win_next [gb3_pkg::WIN_SIZE];
    gb3_pkg::pix_t blur_px;
    logic [SUM_W-1:0] sum_ch [gb3_pkg::CHANNELS];

    always_comb
    begin
        win_next = win_reg;
        if (s1_ctrl.valid && s1_ctrl.pixel)
        begin
            win_next[0] = win_reg[1];
            win_next[1] = win_reg[2];
            win_next[2] = up_rd;
            win_next[3] = win_reg[4];
            win_next[4] = win_reg[5];
            win_next[5] = mid_rd;
            win_next[6] = win_reg[7];
            win_next[7] = win_reg[8];
            win_next[8] = s1_px;
        end
    end

    always_comb
    begin
        blur_px = '0;
        for (int ch = 0; ch < gb3_pkg::CHANNELS; ch++)
        begin
            sum_ch[ch] = SUM_W'(win_next[0][ch*CH_W +: CH_W]) +
                         (SUM_W'(win_next[1][ch*CH_W +: CH_W]) << 1) +
                         SUM_W'(win_next[2][ch*CH_W +: CH_W]) +
                         (SUM_W'(win_next[3][ch*CH_W +: CH_W]) << 1) +
                         (SUM_W'(win_next[4][ch*CH_W +: CH_W]) << 2) +
                         (SUM_W'(win_next[5][ch*CH_W +: CH_W]) << 1) +
                         SUM_W'(win_next[6][ch*CH_W +: CH_W]) +
                         (SUM_W'(win_next[7][ch*CH_W +: CH_W]) << 1) +
                         SUM_W'(win_next[8][ch*CH_W +: CH_W]);
            blur_px[ch*CH_W +: CH_W] = sum_ch[ch][SUM_W-1:SUM_W-CH_W];
        end
    end

    always_comb
    begin
        push = s1_ctrl.valid && s1_ctrl.emit;
        if (s1_ctrl.pixel)
        begin
            push_item.pix       = s1_ctrl.interior ? blur_px : win_next[4];
            push_item.frame_end = 1'b0;
        end
        else
        begin
            push_item.pix       = s1_ctrl.sel_mid ? mid_rd : up_rd;
            push_item.frame_end = s1_ctrl.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < gb3_pkg::WIN_SIZE; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            win_reg <= win_next;
        end
    end

endmodule

`default_nettype wire

[src/gb3_out_fifo.sv]
// Three-entry result queue between the blur stage and the output channel.
// Uses gb3_pkg; reports when a further input transaction could overflow it.
`default_nettype none

module gb3_out_fifo (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire gb3_pkg::out_item_t  push_item,
    input  wire logic                out_stall,
    output logic                     out_valid,
    output gb3_pkg::out_item_t       out_item,
    output logic                     full
);

    localparam int PTR_W = gb3_pkg::OUT_PTR_W;
    localparam int CNT_W = gb3_pkg::OUT_CNT_W;
    localparam int SUM_W = CNT_W + 1;

    gb3_pkg::out_item_t fifo_mem [gb3_pkg::OUT_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               pop;

    assign out_valid = (count_reg != '0);
    assign out_item  = fifo_mem[rd_ptr_reg];
    assign pop       = out_valid && !out_stall;
    assign full      = (SUM_W'(count_reg) + SUM_W'(push)) >= SUM_W'(gb3_pkg::OUT_DEPTH);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(gb3_pkg::OUT_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(gb3_pkg::OUT_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // A result is never pushed into a queue that is already full.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(push && !pop && (count_reg == CNT_W'(gb3_pkg::OUT_DEPTH))))
        else $error("result queue overflow");

endmodule

`default_nettype wire

[src/gaussian_blur_3x3_rgba_top.sv]
// Top level of the 3x3 binomial RGBA blur over a raster pixel stream.
// Depends on gb3_pkg, gb3_ctrl, gb3_line_store, gb3_window and gb3_out_fifo.
//
//   Channel   Handshake             Payload
//   input     in_valid / in_stall   func, in_red, in_green, in_blue, in_alpha
//   output    out_valid / out_stall out_red, out_green, out_blue, out_alpha, frame_end
//   config    cfg_wr_en             cfg_index, cfg_data
//
// One transaction per clock is accepted while in_stall is low; a result passes through
// the stage-one registers and the registered line memory read into the output queue.
// After reset all MAX_WIDTH entries of the line memories are cleared, during which
// in_stall is high; configuration writes are taken at any time.
// Once cleared, in_stall rises only when the three-entry output queue could overflow.
`default_nettype none

module gaussian_blur_3x3_rgba_top #(
    parameter int MAX_WIDTH = gb3_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic                            func,
    input  wire logic [gb3_pkg::CH_W-1:0]        in_red,
    input  wire logic [gb3_pkg::CH_W-1:0]        in_green,
    input  wire logic [gb3_pkg::CH_W-1:0]        in_blue,
    input  wire logic [gb3_pkg::CH_W-1:0]        in_alpha,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [gb3_pkg::CH_W-1:0]             out_red,
    output logic [gb3_pkg::CH_W-1:0]             out_green,
    output logic [gb3_pkg::CH_W-1:0]             out_blue,
    output logic [gb3_pkg::CH_W-1:0]             out_alpha,
    output logic                                 frame_end,
    input  wire logic                            cfg_wr_en,
    input  wire logic [gb3_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [gb3_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic               accept;
    logic               rd_en;
    logic [COL_W-1:0]   rd_addr;
    gb3_pkg::s1_ctrl_t  s1_ctrl;
    logic [COL_W-1:0]   s1_addr;
    gb3_pkg::pix_t      s1_px;
    gb3_pkg::pix_t      in_px;
    gb3_pkg::pix_t      up_rd;
    gb3_pkg::pix_t      mid_rd;
    logic               clr_busy;
    logic               push;
    gb3_pkg::out_item_t push_item;
    gb3_pkg::out_item_t out_item;
    logic               full;

    assign in_px    = {in_alpha, in_blue, in_green, in_red};
    assign in_stall = clr_busy || full;
    assign accept   = in_valid && !in_stall;

    gb3_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .func      (func),
        .in_px     (in_px),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .s1_ctrl   (s1_ctrl),
        .s1_addr   (s1_addr),
        .s1_px     (s1_px)
    );

    gb3_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .wr_en    (s1_ctrl.valid && s1_ctrl.pixel),
        .wr_addr  (s1_addr),
        .wr_px    (s1_px),
        .up_rd    (up_rd),
        .mid_rd   (mid_rd),
        .clr_busy (clr_busy)
    );

    gb3_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1_ctrl   (s1_ctrl),
        .s1_px     (s1_px),
        .up_rd     (up_rd),
        .mid_rd    (mid_rd),
        .push      (push),
        .push_item (push_item)
    );

    gb3_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_item  (out_item),
        .full      (full)
    );

    assign out_red   = out_item.pix[0*gb3_pkg::CH_W +: gb3_pkg::CH_W];
    assign out_green = out_item.pix[1*gb3_pkg::CH_W +: gb3_pkg::CH_W];
    assign out_blue  = out_item.pix[2*gb3_pkg::CH_W +: gb3_pkg::CH_W];
    assign out_alpha = out_item.pix[3*gb3_pkg::CH_W +: gb3_pkg::CH_W];
    assign frame_end = out_item.frame_end;

endmodule

`default_nettype wire
